>>> design/sha1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

    // initial chaining words
    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    // round constants, one per group of 20 rounds
    localparam logic [31:0] K_GRP0 = 32'h5A827999;
    localparam logic [31:0] K_GRP1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_GRP2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_GRP3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_GRP1 = 7'd20;
    localparam logic [6:0] ROUND_GRP2 = 7'd40;
    localparam logic [6:0] ROUND_GRP3 = 7'd60;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] BYTE_POS_LAST = 6'd63;
    localparam logic [2:0] WORD_IDX_LAST = 3'd4;

    typedef enum logic [1:0] {
        PAD_MARK = 2'd0,
        PAD_ZERO = 2'd1,
        PAD_LEN  = 2'd2
    } t_pad_sel;

    typedef struct packed {
        logic     load_byte;   // input beat accepted
        logic     pad_start;   // latch length and pad position
        logic     pad_shift;   // shift one pad byte into the block
        t_pad_sel pad_sel;
        logic     comp_load;   // working vars from chaining words
        logic     comp_round;  // one compression round
        logic     comp_add;    // fold working vars into chaining words
        logic     emit;        // move digest to output, reinit chain
    } t_dp_cmd;

    typedef struct packed {
        logic byte_pos_last;   // next message byte fills the block
        logic pad_pos_last;    // next pad byte fills the block
        logic pad_pos_tail;    // pad position is in the length field
        logic round_last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> design/sha1_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sha1_dp (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sha1_pkg::t_dp_cmd i_cmd,
    output sha1_pkg::t_dp_sts     o_sts,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_has_byte,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_digest_word,
    output logic [2:0]            o_word_index,
    output logic                  o_last_word
);

    logic [511:0] r_blk;
    logic [63:0]  r_count;
    logic [63:0]  n_count;
    logic [63:0]  r_len;
    logic [5:0]   r_pos;
    logic [6:0]   r_round;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  r_h [5];
    logic [159:0] r_obuf;
    logic         r_ovalid;
    logic [2:0]   r_oidx;

    logic [63:0]  len_sh;
    logic [7:0]   pad_byte;
    logic [31:0]  w0, w2, w8, w13, w_mix, w_new;
    logic [31:0]  f, k, t;

    assign n_count = r_count + (i_has_byte ? 64'd8 : 64'd0);

    // length bytes go out most significant first
    assign len_sh = r_len << {r_pos[2:0], 3'b000};

    always_comb begin
        unique case (i_cmd.pad_sel)
            sha1_pkg::PAD_MARK: pad_byte = sha1_pkg::PAD_MARK_BYTE;
            sha1_pkg::PAD_LEN:  pad_byte = len_sh[63:56];
            default:            pad_byte = 8'h00;
        endcase
    end

    // schedule window: word j of the window sits at bits 511-32j
    assign w0    = r_blk[511:480];
    assign w2    = r_blk[447:416];
    assign w8    = r_blk[255:224];
    assign w13   = r_blk[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        priority if (r_round < sha1_pkg::ROUND_GRP1) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = sha1_pkg::K_GRP0;
        end else if (r_round < sha1_pkg::ROUND_GRP2) begin
            f = r_b ^ r_c ^ r_d;
            k = sha1_pkg::K_GRP1;
        end else if (r_round < sha1_pkg::ROUND_GRP3) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = sha1_pkg::K_GRP2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = sha1_pkg::K_GRP3;
        end
    end

    assign t = {r_a[26:0], r_a[31:27]} + f + r_e + k + w0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte && i_has_byte) begin
            r_blk <= {r_blk[503:0], i_data_byte};
        end else if (i_cmd.pad_shift) begin
            r_blk <= {r_blk[503:0], pad_byte};
        end else if (i_cmd.comp_round) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pad_start) begin
            r_len <= n_count;
            r_pos <= n_count[8:3];
        end else if (i_cmd.pad_shift) begin
            r_pos <= r_pos + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.comp_round) begin
            r_a <= t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_round <= '0;
            r_h[0]  <= sha1_pkg::H_INIT0;
            r_h[1]  <= sha1_pkg::H_INIT1;
            r_h[2]  <= sha1_pkg::H_INIT2;
            r_h[3]  <= sha1_pkg::H_INIT3;
            r_h[4]  <= sha1_pkg::H_INIT4;
        end else begin
            if (i_cmd.emit) begin
                r_count <= '0;
            end else if (i_cmd.load_byte) begin
                r_count <= n_count;
            end

            if (i_cmd.comp_load) begin
                r_round <= '0;
            end else if (i_cmd.comp_round) begin
                r_round <= r_round + 7'd1;
            end

            if (i_cmd.emit) begin
                r_h[0] <= sha1_pkg::H_INIT0;
                r_h[1] <= sha1_pkg::H_INIT1;
                r_h[2] <= sha1_pkg::H_INIT2;
                r_h[3] <= sha1_pkg::H_INIT3;
                r_h[4] <= sha1_pkg::H_INIT4;
            end else if (i_cmd.comp_add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    // digest output register, drained one word per beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_obuf <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
        end else if (r_ovalid && i_out_ready) begin
            r_obuf <= {r_obuf[127:0], 32'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
            r_oidx   <= '0;
        end else if (r_ovalid && i_out_ready) begin
            r_oidx <= r_oidx + 3'd1;
            if (r_oidx == sha1_pkg::WORD_IDX_LAST) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_digest_word = r_obuf[159:128];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == sha1_pkg::WORD_IDX_LAST);

    assign o_sts.byte_pos_last = (r_count[8:3] == sha1_pkg::BYTE_POS_LAST);
    assign o_sts.pad_pos_last  = (r_pos == sha1_pkg::BYTE_POS_LAST);
    assign o_sts.pad_pos_tail  = (r_pos[5:3] == 3'b111);
    assign o_sts.round_last    = (r_round == sha1_pkg::ROUND_LAST);
    assign o_sts.out_busy      = r_ovalid;

endmodule

`default_nettype wire

>>> design/sha1_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sha1_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_has_byte,
    input  wire logic              i_is_last,
    output logic                   o_in_ready,
    input  wire sha1_pkg::t_dp_sts i_sts,
    output sha1_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PAD    = 6'b000010,
        ST_CLOAD  = 6'b000100,
        ST_CROUND = 6'b001000,
        ST_CADD   = 6'b010000,
        ST_FIN    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_sent80, n_sent80;
    logic   r_tail, n_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_sent80 <= 1'b0;
            r_tail   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_sent80 <= n_sent80;
            r_tail   <= n_tail;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_sent80   = r_sent80;
        n_tail     = r_tail;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.pad_sel = sha1_pkg::PAD_ZERO;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_byte = 1'b1;
                    o_cmd.pad_start = i_is_last;
                    if (i_has_byte && i_sts.byte_pos_last) begin
                        n_state = ST_CLOAD;
                        n_ret   = i_is_last ? ST_PAD : ST_IDLE;
                    end else if (i_is_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.pad_shift = 1'b1;
                priority if (!r_sent80) begin
                    o_cmd.pad_sel = sha1_pkg::PAD_MARK;
                end else if (i_sts.pad_pos_tail && !r_tail) begin
                    o_cmd.pad_sel = sha1_pkg::PAD_LEN;
                end else begin
                    o_cmd.pad_sel = sha1_pkg::PAD_ZERO;
                end
                n_sent80 = 1'b1;
                // a mark in the length field pushes the length to the next block
                if (i_sts.pad_pos_last) begin
                    n_tail = 1'b0;
                end else if (!r_sent80) begin
                    n_tail = i_sts.pad_pos_tail;
                end
                if (i_sts.pad_pos_last) begin
                    n_state = ST_CLOAD;
                    n_ret   = (r_sent80 && !r_tail) ? ST_FIN : ST_PAD;
                end
            end
            ST_CLOAD: begin
                o_cmd.comp_load = 1'b1;
                n_state = ST_CROUND;
            end
            ST_CROUND: begin
                o_cmd.comp_round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = ST_CADD;
                end
            end
            ST_CADD: begin
                o_cmd.comp_add = 1'b1;
                n_state = r_ret;
            end
            ST_FIN: begin
                // hold until the previous digest has drained
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_sent80 = 1'b0;
                    n_tail   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/sha1_byte_stream_hasher.sv
// SHA-1 hasher over a byte stream.
// Input channel (i_in_valid / o_in_ready): one beat carries i_data_byte, i_has_byte and
// i_is_last. A byte is appended when i_has_byte is set; i_is_last ends the message
// after that byte (or with no byte), and a beat with neither changes nothing.
// Output channel (o_out_valid / i_out_ready): five beats per message, digest word 0
// first, o_word_index 0..4, o_last_word on the fifth.
// A byte that completes a 64-byte block adds a compression (load, 80 rounds on the
// single round unit, chaining add). Finishing shifts in one pad byte per cycle up to
// the end of the block, with one compression per padded block (one or two), then the
// finish state loads the digest into the output register.
// The input is taken only while no block work is running. Digest words wait in an
// output register, so new bytes are accepted while the receiver stalls; the next
// finish waits until the previous digest has fully drained.
// Reset loads the standard initial chaining words, clears the bit count and drops
// any pending digest.
`timescale 1ns / 1ps
`default_nettype none

module sha1_byte_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    sha1_pkg::t_dp_cmd cmd;
    sha1_pkg::t_dp_sts sts;

    sha1_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_has_byte (i_has_byte),
        .i_is_last  (i_is_last),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sha1_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // a finish always occupies the block for at least the padding cycle
    a_last_busies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_is_last |=> !o_in_ready)
        else $error("input accepted right after a finishing beat");

    // digest words advance by one per beat
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_word |=>
        o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

    // only one digest is in flight at a time
    a_single_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_word |=> !o_out_valid)
        else $error("new digest started on the beat after the last word");

endmodule

`default_nettype wire
